// ===== rtl/pfe_pkg.sv =====
// Shared types, constants and helper functions for the Playfair digraph encryptor.
package pfe_pkg;

    localparam int SQ_SIDE     = 5;
    localparam int LETTER_W    = 5;
    localparam int POS_W       = 3;
    localparam int CFG_DATA_W  = 50;
    localparam int CFG_INDEX_W = 2;

    localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;

    localparam logic [CFG_INDEX_W-1:0] REG_SQ_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SQ_SECOND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SQ_LAST   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FILLER    = 2'd3;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [POS_W-1:0]    pos_idx_t;
    typedef letter_t [SQ_SIDE-1:0][SQ_SIDE-1:0] grid_t;

    typedef struct packed {
        letter_t a;
        letter_t b;
        logic    last;
    } pair_t;

    typedef struct packed {
        pos_idx_t row;
        pos_idx_t col;
    } pos_t;

    typedef struct packed {
        pos_t pa;
        pos_t pb;
        logic last;
    } loc_t;

    function automatic letter_t fold_j(letter_t v);
        return (v == LETTER_J) ? LETTER_I : v;
    endfunction

    function automatic pos_idx_t wrap_inc(pos_idx_t v);
        return (v == pos_idx_t'(SQ_SIDE - 1)) ? '0 : v + pos_idx_t'(1);
    endfunction

    // lowest matching cell wins; no match gives row 0, column 0
    function automatic pos_t locate(grid_t grid, letter_t letter);
        pos_t p;
        p = '0;
        for (int r = SQ_SIDE - 1; r >= 0; r--) begin
            for (int c = SQ_SIDE - 1; c >= 0; c--) begin
                if (grid[r][c] == letter) begin
                    p.row = pos_idx_t'(r);
                    p.col = pos_idx_t'(c);
                end
            end
        end
        return p;
    endfunction

endpackage

// ===== rtl/playfair_digraph_encrypt.sv =====
// Top level of the Playfair digraph encryptor with its configuration registers.
//
// Input channel: plaintext letters 0..25 (J is taken as I) with message_end on
// the last letter; a transfer happens when push is high and full is low.
// Output channel: ciphertext letters; the oldest waiting letter is shown while
// empty is low and is transferred when pop is high. final_letter marks the last
// ciphertext letter of a message.
// Configuration: cfg_write with cfg_index 0..2 loads the 5x5 key square, cells
// packed five bits each, lowest cell in the low bits; index 3 sets the filler.
// Write only while the block is idle.
// Each input letter causes 0, 2 or 4 output letters at one per cycle while pop
// stays high, so output sets the rate: plain text is taken at one letter per
// cycle, doubled letters more slowly, as each yields a whole digraph. A doubled
// pair at message end holds full high while its second digraph waits to enter
// the pair queue. A completed digraph passes through the pair queue, the lookup
// register and the encrypt register, whose load clears empty.
// A stalled receiver fills the output register, the lookup stage and the pair
// queue, then full rises; nothing is lost. Reset clears the held letter and all
// queues and loads the default square MONARCHYBDEFGIKLPQSTUVWXZ with filler X.
module playfair_digraph_encrypt #(
    parameter int PAIR_DEPTH = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [pfe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pfe_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic [pfe_pkg::LETTER_W-1:0]       plain_letter,
    input  logic                               message_end,
    output logic                               empty,
    input  logic                               pop,
    output logic [pfe_pkg::LETTER_W-1:0]       cipher_letter,
    output logic                               final_letter
);
    import pfe_pkg::*;

    localparam int SQ_BITS_TEN  = 10 * LETTER_W;
    localparam int SQ_BITS_FIVE = SQ_SIDE * LETTER_W;

    logic [SQ_BITS_TEN-1:0]  sq_first_reg;
    logic [SQ_BITS_TEN-1:0]  sq_second_reg;
    logic [SQ_BITS_FIVE-1:0] sq_last_reg;
    letter_t                 filler_reg;

    grid_t grid;
    logic  pair_wr, pair_rd, fifo_full, fifo_empty;
    pair_t wr_pair, rd_pair;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sq_first_reg  <= 50'd107484862756300;
            sq_second_reg <= 50'd688860520781988;
            sq_last_reg   <= 25'd26991284;
            filler_reg    <= 5'd23;
        end
        else if (cfg_write) begin
            case (cfg_index)
                REG_SQ_FIRST:  sq_first_reg  <= cfg_data[SQ_BITS_TEN-1:0];
                REG_SQ_SECOND: sq_second_reg <= cfg_data[SQ_BITS_TEN-1:0];
                REG_SQ_LAST:   sq_last_reg   <= cfg_data[SQ_BITS_FIVE-1:0];
                REG_FILLER:    filler_reg    <= cfg_data[LETTER_W-1:0];
                default:       filler_reg    <= filler_reg;
            endcase
        end
    end

    always_comb
    begin
        for (int r = 0; r < SQ_SIDE; r++) begin
            for (int c = 0; c < SQ_SIDE; c++) begin
                if (r * SQ_SIDE + c < 10) begin
                    grid[r][c] = sq_first_reg[(r * SQ_SIDE + c) * LETTER_W +: LETTER_W];
                end
                else if (r * SQ_SIDE + c < 20) begin
                    grid[r][c] = sq_second_reg[(r * SQ_SIDE + c - 10) * LETTER_W +: LETTER_W];
                end
                else begin
                    grid[r][c] = sq_last_reg[(r * SQ_SIDE + c - 20) * LETTER_W +: LETTER_W];
                end
            end
        end
    end

    pfe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .plain_letter (plain_letter),
        .message_end  (message_end),
        .filler       (filler_reg),
        .fifo_full    (fifo_full),
        .pair_wr      (pair_wr),
        .pair_data    (wr_pair)
    );

    pfe_pair_fifo #(
        .DEPTH (PAIR_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (pair_wr),
        .wr_data (wr_pair),
        .full    (fifo_full),
        .rd      (pair_rd),
        .rd_data (rd_pair),
        .empty   (fifo_empty)
    );

    pfe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .grid          (grid),
        .pair_valid    (!fifo_empty),
        .pair_in       (rd_pair),
        .pair_rd       (pair_rd),
        .empty         (empty),
        .pop           (pop),
        .cipher_letter (cipher_letter),
        .final_letter  (final_letter)
    );

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        pair_wr |-> !fifo_full)
        else $error("pair written into a full queue");

    a_no_read_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pair_rd |-> !fifo_empty)
        else $error("pair read from an empty queue");

    a_full_on_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_full |-> full)
        else $error("input not held off with pair queue full");

endmodule

// ===== rtl/pfe_front.sv =====
// Front end: accepts plaintext letters, forms digraphs and inserts filler.
module pfe_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  pfe_pkg::letter_t plain_letter,
    input  logic           message_end,
    input  pfe_pkg::letter_t filler,
    input  logic           fifo_full,
    output logic           pair_wr,
    output pfe_pkg::pair_t pair_data
);
    import pfe_pkg::*;

    logic    held_valid_reg, held_valid_next;
    letter_t held_reg, held_next;
    logic    pend_valid_reg, pend_valid_next;
    pair_t   pend_reg, pend_next;

    logic    acc;
    letter_t p;
    letter_t f;
    logic    first_vld;
    pair_t   first_pair;
    logic    second_vld;
    pair_t   second_pair;

    assign full = pend_valid_reg || fifo_full;
    assign acc  = push && !full;
    assign p    = fold_j(plain_letter);
    assign f    = fold_j(filler);

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        first_vld       = 1'b0;
        first_pair      = '{a: p, b: f, last: 1'b1};
        second_vld      = 1'b0;
        second_pair     = '{a: p, b: f, last: 1'b1};
        if (!held_valid_reg) begin
            if (message_end) begin
                first_vld = 1'b1;
            end
            else begin
                held_next       = p;
                held_valid_next = 1'b1;
            end
        end
        else if (p != held_reg) begin
            first_vld       = 1'b1;
            first_pair      = '{a: held_reg, b: p, last: message_end};
            held_valid_next = 1'b0;
        end
        else begin
            first_vld  = 1'b1;
            first_pair = '{a: held_reg, b: f, last: 1'b0};
            if (message_end) begin
                second_vld      = 1'b1;
                held_valid_next = 1'b0;
            end
            else begin
                held_next = p;
            end
        end
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (pend_valid_reg) begin
            pair_wr   = !fifo_full;
            pair_data = pend_reg;
            if (!fifo_full) begin
                pend_valid_next = 1'b0;
            end
        end
        else begin
            pair_wr   = acc && first_vld;
            pair_data = first_pair;
            if (acc && second_vld) begin
                pend_valid_next = 1'b1;
                pend_next       = second_pair;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_valid_reg <= 1'b0;
            held_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else begin
            pend_valid_reg <= pend_valid_next;
            if (acc) begin
                held_valid_reg <= held_valid_next;
                held_reg       <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

// ===== rtl/pfe_pair_fifo.sv =====
// Short queue of digraphs between the front end and the encrypt back end.
module pfe_pair_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  pfe_pkg::pair_t wr_data,
    output logic           full,
    input  logic           rd,
    output pfe_pkg::pair_t rd_data,
    output logic           empty
);
    import pfe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pair_t           mem [DEPTH];
    logic [AW-1:0]   wptr_reg, rptr_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_wr, do_rd;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else begin
            if (do_wr) begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
            end
            if (do_rd) begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + AW'(1);
            end
            case ({do_wr, do_rd})
                2'b10:   cnt_reg <= cnt_reg + CW'(1);
                2'b01:   cnt_reg <= cnt_reg - CW'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ===== rtl/pfe_back.sv =====
// Back end: locates a digraph in the key square, encrypts it, emits two letters.
module pfe_back (
    input  logic            clk,
    input  logic            rst_n,
    input  pfe_pkg::grid_t  grid,
    input  logic            pair_valid,
    input  pfe_pkg::pair_t  pair_in,
    output logic            pair_rd,
    output logic            empty,
    input  logic            pop,
    output pfe_pkg::letter_t cipher_letter,
    output logic            final_letter
);
    import pfe_pkg::*;

    logic    loc_valid_reg;
    loc_t    loc_reg;
    logic    ov_reg;
    logic    phase_reg;
    letter_t ea_reg, eb_reg;
    logic    olast_reg;

    logic    pop_ok, out_free, loc_adv, loc_take;
    letter_t ea, eb;
    loc_t    l;

    assign empty    = !ov_reg;
    assign pop_ok   = pop && ov_reg;
    assign out_free = !ov_reg || (phase_reg && pop_ok);
    assign loc_adv  = loc_valid_reg && out_free;
    assign loc_take = !loc_valid_reg || loc_adv;
    assign pair_rd  = pair_valid && loc_take;

    assign cipher_letter = phase_reg ? eb_reg : ea_reg;
    assign final_letter  = phase_reg && olast_reg;

    assign l = loc_reg;

    always_comb
    begin
        if (l.pa.row == l.pb.row) begin
            ea = grid[l.pa.row][wrap_inc(l.pa.col)];
            eb = grid[l.pb.row][wrap_inc(l.pb.col)];
        end
        else if (l.pa.col == l.pb.col) begin
            ea = grid[wrap_inc(l.pa.row)][l.pa.col];
            eb = grid[wrap_inc(l.pb.row)][l.pb.col];
        end
        else begin
            ea = grid[l.pa.row][l.pb.col];
            eb = grid[l.pb.row][l.pa.col];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            loc_valid_reg <= 1'b0;
            ov_reg        <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else begin
            if (loc_take) begin
                loc_valid_reg <= pair_valid;
            end
            if (pop_ok) begin
                if (!phase_reg) begin
                    phase_reg <= 1'b1;
                end
                else begin
                    phase_reg <= 1'b0;
                    ov_reg    <= 1'b0;
                end
            end
            if (loc_adv) begin
                ov_reg    <= 1'b1;
                phase_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_rd) begin
            loc_reg <= '{pa: locate(grid, pair_in.a), pb: locate(grid, pair_in.b),
                         last: pair_in.last};
        end
        if (loc_adv) begin
            ea_reg    <= ea;
            eb_reg    <= eb;
            olast_reg <= l.last;
        end
    end

endmodule
